FILE: rtl/core/ate_pkg.sv
// Package for the array table engine: sizes, command and status codes,
// and the shared controller/datapath command and status structs. No dependencies.
package ate_pkg;
  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  localparam logic [3:0] CMD_CLEAR   = 4'd0;
  localparam logic [3:0] CMD_APPEND  = 4'd1;
  localparam logic [3:0] CMD_DUMP    = 4'd2;
  localparam logic [3:0] CMD_PRIMES  = 4'd3;
  localparam logic [3:0] CMD_SECMIN  = 4'd4;
  localparam logic [3:0] CMD_INSERT  = 4'd5;
  localparam logic [3:0] CMD_DELETE  = 4'd6;
  localparam logic [3:0] CMD_SORTD   = 4'd7;
  localparam logic [3:0] CMD_SEARCH  = 4'd8;
  localparam logic [3:0] CMD_REVERSE = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_IDX  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_TOO_FEW  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Memory operation issued by the controller to the datapath.
  typedef enum logic [1:0] {MOP_NONE, MOP_READ, MOP_WRITE} mop_t;

  typedef struct packed {
    mop_t        op;
    logic [AW-1:0] addr;
    logic [31:0] wdata;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] rdata;
  } dp_stat_t;
endpackage

FILE: rtl/core/ate_if.sv
// Valid/ready channel interfaces for the array table engine.
// Depends on ate_pkg.
interface ate_req_if import ate_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] operand_value;
  logic [6:0]  position;
  modport source (output valid, command, operand_value, position, input ready);
  modport sink   (input valid, command, operand_value, position, output ready);
endinterface

interface ate_rsp_if import ate_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] result_value;
  logic [5:0]  first_index;
  logic [5:0]  final_index;
  logic [6:0]  tally;
  logic        last;
  modport source (output valid, status, result_value, first_index, final_index, tally, last,
                  input ready);
  modport sink   (input valid, status, result_value, first_index, final_index, tally, last,
                  output ready);
endinterface

FILE: rtl/core/array_table_engine_top.sv
// Top level of the array table engine: sequencer plus element store.
// Depends on ate_pkg, ate_if, ate_ctrl, ate_datapath.
//
// Usage: one request on req carries command, operand_value and position.
// Each command produces one response on rsp, except dump, which produces
// one response per element with last set on the final one. Commands 10..15
// produce nothing and change nothing.
// A simple command's response is registered in the emit state that follows
// the idle state taking the request. Dump reads, waits and outputs each element.
// Insert/delete read, wait and write each element moved; reverse reads both
// ends of a pair, then writes both.
// Sorts (second min, sort descending, search) run an insertion sort on the
// single memory port; search adds a binary search.
// Primes run a bit-serial restoring divider per trial divisor, trying divisors
// up to the square root of the value.
// One request is worked at a time; req.ready is low until the last response
// has left the output register.
// Reset clears the length and the control state; the element memory is not
// cleared and is only read below the length.
// A stalled receiver holds the output register; dump waits for it.
module array_table_engine_top import ate_pkg::*; (
  input logic clk,
  input logic rst,
  ate_req_if.sink   req,
  ate_rsp_if.source rsp
);
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  ate_ctrl u_ctrl (.clk, .rst, .req, .rsp, .dcmd, .dstat);
  ate_datapath u_dp (.clk, .cmd(dcmd), .stat(dstat));

`ifndef NO_ASSERTIONS
  // Never take a request while a response is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken while response pending");
  // Held response must stay stable under stall.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
    else $error("response dropped under stall");
  // Status codes stay in range.
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status <= ST_NOTFOUND) else $error("bad status");
`endif
endmodule

FILE: rtl/core/ate_datapath.sv
// Element store of the array table engine: one-port memory, registered read.
// Depends on ate_pkg.
module ate_datapath import ate_pkg::*; (
  input  logic     clk,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);
  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.op == MOP_WRITE) mem[cmd.addr] <= cmd.wdata;
    stat.rdata <= mem[cmd.addr];
  end
endmodule

FILE: rtl/core/ate_ctrl.sv
// Command sequencer of the array table engine: walks the element store one
// access at a time. Depends on ate_pkg.
module ate_ctrl import ate_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ate_req_if.sink  req,
  ate_rsp_if.source rsp,
  output dp_cmd_t  dcmd,
  input  dp_stat_t dstat
);
  typedef enum logic [4:0] {
    S_IDLE, S_EMIT, S_DUMP_RD, S_DUMP_WT, S_DUMP_OUT,
    S_PR_RD, S_PR_WT, S_PR_DIV, S_PR_STEP,
    S_SO_KEY, S_SO_KEYW, S_SO_RD, S_SO_WT, S_SO_CMP,
    S_SH_RD, S_SH_WT, S_SH_WR,
    S_SM_RD0, S_SM_W0, S_SM_RD, S_SM_WT, S_SM_CMP,
    S_BS_RD, S_BS_WT, S_BS_CMP, S_BS_EXT, S_BS_EWT,
    S_RV_RDA, S_RV_RDB, S_RV_WT, S_RV_WA, S_RV_WB
  } state_t;

  state_t state;
  logic [3:0]  cmd;
  logic [31:0] val;
  logic [LW-1:0] pos, length;
  logic [LW-1:0] i, j, lo, hi, fin;
  logic [31:0] key, tmp, ref0;
  logic [LW-1:0] cnt;
  // trial division
  logic [31:0] dvs, rem;
  logic [5:0]  bitc;
  logic [63:0] dsq;

  // output register
  logic [2:0]  o_st;
  logic [31:0] o_val;
  logic [5:0]  o_fi, o_la;
  logic [6:0]  o_ta;
  logic        o_last, o_valid;

  function automatic logic lt_s(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  assign req.ready = (state == S_IDLE) && !o_valid;
  assign rsp.valid = o_valid;
  assign rsp.status = o_st;
  assign rsp.result_value = o_val;
  assign rsp.first_index = o_fi;
  assign rsp.final_index = o_la;
  assign rsp.tally = o_ta;
  assign rsp.last = o_last;

  logic [32:0] rem_sh;
  logic [LW:0] mid_sum;
  logic [LW-1:0] mid;
  assign rem_sh = {rem, val[31]};
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[LW:1];

  always_ff @(posedge clk) begin
    dcmd.op <= MOP_NONE;
    if (rsp.valid && rsp.ready) o_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      length <= '0;
      o_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          cmd <= req.command; val <= req.operand_value; pos <= req.position;
          o_st <= ST_OK; o_val <= '0; o_fi <= '0; o_la <= '0; o_last <= 1'b1;
          o_ta <= 7'(length);
          i <= '0; cnt <= '0;
          unique case (req.command)
            CMD_CLEAR: begin length <= '0; o_ta <= '0; state <= S_EMIT; end
            CMD_APPEND: if (length >= LW'(CAPACITY)) begin
              o_st <= ST_FULL; state <= S_EMIT;
            end else begin
              dcmd <= '{MOP_WRITE, length[AW-1:0], req.operand_value};
              length <= length + 1'b1; o_ta <= 7'(length + 1'b1); state <= S_EMIT;
            end
            CMD_DUMP: if (length == '0) begin
              o_st <= ST_TOO_FEW; state <= S_EMIT;
            end else state <= S_DUMP_RD;
            CMD_PRIMES: state <= S_PR_RD;
            CMD_SECMIN: if (length < LW'(2)) begin
              o_st <= ST_TOO_FEW; state <= S_EMIT;
            end else begin i <= LW'(1); state <= S_SO_KEY; end
            CMD_INSERT: if (length >= LW'(CAPACITY)) begin
              o_st <= ST_FULL; state <= S_EMIT;
            end else if (req.position > 7'(length)) begin
              o_st <= ST_BAD_IDX; state <= S_EMIT;
            end else begin i <= length; state <= S_SH_RD; end
            CMD_DELETE: if (req.position >= 7'(length)) begin
              o_st <= ST_BAD_IDX; state <= S_EMIT;
            end else begin i <= LW'(req.position); state <= S_SH_RD; end
            CMD_SORTD, CMD_SEARCH: begin i <= LW'(1); state <= S_SO_KEY; end
            CMD_REVERSE: begin lo <= '0; hi <= length; state <= S_RV_RDA; end
            default: state <= S_IDLE;
          endcase
        end
        S_EMIT: begin o_valid <= 1'b1; state <= S_IDLE; end
        // dump: one result per element, hold while the receiver stalls
        S_DUMP_RD: if (!o_valid || rsp.ready) begin
          dcmd <= '{MOP_READ, i[AW-1:0], '0}; state <= S_DUMP_WT;
        end
        S_DUMP_WT: state <= S_DUMP_OUT;
        S_DUMP_OUT: begin
          o_val <= dstat.rdata; o_fi <= i[5:0]; o_last <= (i + 1'b1 == length);
          o_valid <= 1'b1; i <= i + 1'b1;
          state <= (i + 1'b1 == length) ? S_IDLE : S_DUMP_RD;
        end
        // primes: restoring division of the value by each trial divisor
        S_PR_RD: if (i == length) begin
          o_ta <= 7'(cnt); state <= S_EMIT;
        end else begin
          dcmd <= '{MOP_READ, i[AW-1:0], '0}; state <= S_PR_WT;
        end
        S_PR_WT: state <= S_PR_STEP;
        S_PR_STEP: begin
          if (bitc == 6'd0 && state == S_PR_STEP && dvs == '0) begin
            key <= dstat.rdata;
            if (dstat.rdata[31] || dstat.rdata < 32'd2) begin
              i <= i + 1'b1; state <= S_PR_RD;
            end else begin
              dvs <= 32'd2; dsq <= 64'd4;
            end
          end else if (bitc == 6'd0) begin
            if (dsq > {32'd0, key}) begin
              cnt <= cnt + 1'b1; dvs <= '0; i <= i + 1'b1; state <= S_PR_RD;
            end else begin
              val <= key; rem <= '0; bitc <= 6'd32; state <= S_PR_DIV;
            end
          end
        end
        S_PR_DIV: begin
          rem <= (rem_sh >= {1'b0, dvs}) ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
          val <= {val[30:0], 1'b0};
          bitc <= bitc - 1'b1;
          if (bitc == 6'd1) begin
            if (((rem_sh >= {1'b0, dvs}) ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0]) == '0)
            begin
              dvs <= '0; i <= i + 1'b1; state <= S_PR_RD;
            end else begin
              dsq <= dsq + {31'd0, dvs, 1'b0} + 64'd1; dvs <= dvs + 1'b1;
              state <= S_PR_STEP;
            end
          end
        end
        // insertion sort, ascending unless descending sort
        S_SO_KEY: if (i >= length) begin
          unique case (cmd)
            CMD_SECMIN: begin i <= LW'(1); state <= S_SM_RD0; end
            CMD_SEARCH: begin lo <= '0; hi <= length; state <= S_BS_CMP; end
            default: state <= S_EMIT;
          endcase
        end else begin
          dcmd <= '{MOP_READ, i[AW-1:0], '0}; j <= i; state <= S_SO_KEYW;
        end
        S_SO_KEYW: state <= S_SO_RD;
        S_SO_RD: begin
          if (j == i) key <= dstat.rdata;
          if (j == '0) begin
            dcmd <= '{MOP_WRITE, '0, (j == i) ? dstat.rdata : key};
            i <= i + 1'b1; state <= S_SO_KEY;
          end else begin
            dcmd <= '{MOP_READ, AW'(j - 1'b1), '0}; state <= S_SO_WT;
          end
        end
        S_SO_WT: state <= S_SO_CMP;
        S_SO_CMP: if ((cmd == CMD_SORTD) ? lt_s(dstat.rdata, key) : lt_s(key, dstat.rdata))
        begin
          dcmd <= '{MOP_WRITE, j[AW-1:0], dstat.rdata}; j <= j - 1'b1;
          state <= S_SO_RD;
        end else begin
          dcmd <= '{MOP_WRITE, j[AW-1:0], key}; i <= i + 1'b1; state <= S_SO_KEY;
        end
        // insert shifts up from the end, delete shifts down from the position
        S_SH_RD: if (cmd == CMD_INSERT) begin
          if (i == pos) begin
            dcmd <= '{MOP_WRITE, pos[AW-1:0], val};
            length <= length + 1'b1; o_ta <= 7'(length + 1'b1); state <= S_EMIT;
          end else begin
            dcmd <= '{MOP_READ, AW'(i - 1'b1), '0}; state <= S_SH_WT;
          end
        end else begin
          if (i + 1'b1 >= length) begin
            length <= length - 1'b1; o_ta <= 7'(length - 1'b1); state <= S_EMIT;
          end else begin
            dcmd <= '{MOP_READ, AW'(i + 1'b1), '0}; state <= S_SH_WT;
          end
        end
        S_SH_WT: state <= S_SH_WR;
        S_SH_WR: begin
          dcmd <= '{MOP_WRITE, i[AW-1:0], dstat.rdata};
          i <= (cmd == CMD_INSERT) ? i - 1'b1 : i + 1'b1; state <= S_SH_RD;
        end
        // second smallest: scan the sorted array for the first value unlike entry 0
        S_SM_RD0: begin dcmd <= '{MOP_READ, '0, '0}; state <= S_SM_W0; end
        S_SM_W0: state <= S_SM_RD;
        S_SM_RD: begin
          if (i == LW'(1)) ref0 <= dstat.rdata;
          if (i >= length) begin
            o_st <= ST_NOTFOUND; state <= S_EMIT;
          end else begin
            dcmd <= '{MOP_READ, i[AW-1:0], '0}; state <= S_SM_WT;
          end
        end
        S_SM_WT: state <= S_SM_CMP;
        S_SM_CMP: if (dstat.rdata != ref0) begin
          o_val <= dstat.rdata; state <= S_EMIT;
        end else begin
          i <= i + 1'b1; state <= S_SM_RD;
        end
        // lower bound search, then walk forward over equal entries
        S_BS_CMP: if (lo < hi) begin
          dcmd <= '{MOP_READ, mid[AW-1:0], '0}; state <= S_BS_WT;
        end else if (lo >= length) begin
          o_st <= ST_NOTFOUND; state <= S_EMIT;
        end else begin
          dcmd <= '{MOP_READ, lo[AW-1:0], '0}; fin <= lo; state <= S_BS_EWT;
        end
        S_BS_WT: state <= S_BS_RD;
        S_BS_RD: begin
          if (lt_s(dstat.rdata, val)) lo <= mid + 1'b1; else hi <= mid;
          state <= S_BS_CMP;
        end
        S_BS_EWT: state <= S_BS_EXT;
        S_BS_EXT: if (dstat.rdata != val) begin
          if (fin == lo) begin
            o_st <= ST_NOTFOUND; state <= S_EMIT;
          end else begin
            o_fi <= lo[5:0]; o_la <= 6'(fin - 1'b1); state <= S_EMIT;
          end
        end else if (fin + 1'b1 >= length) begin
          o_fi <= lo[5:0]; o_la <= fin[5:0]; state <= S_EMIT;
        end else begin
          dcmd <= '{MOP_READ, AW'(fin + 1'b1), '0}; fin <= fin + 1'b1; state <= S_BS_EWT;
        end
        // reverse: swap pairs from both ends
        S_RV_RDA: if (lo + 1'b1 < hi) begin
          dcmd <= '{MOP_READ, lo[AW-1:0], '0}; state <= S_RV_RDB;
        end else state <= S_EMIT;
        S_RV_RDB: begin dcmd <= '{MOP_READ, AW'(hi - 1'b1), '0}; state <= S_RV_WT; end
        S_RV_WT: begin tmp <= dstat.rdata; state <= S_RV_WA; end
        S_RV_WA: begin
          dcmd <= '{MOP_WRITE, lo[AW-1:0], dstat.rdata}; state <= S_RV_WB;
        end
        S_RV_WB: begin
          dcmd <= '{MOP_WRITE, AW'(hi - 1'b1), tmp};
          lo <= lo + 1'b1; hi <= hi - 1'b1; state <= S_RV_RDA;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && req.valid && req.ready) begin
        fin <= '0; dvs <= '0; bitc <= '0;
      end
    end
  end
endmodule

FILE: verif/ate_checker.sv
// Scoreboard for the array table engine: watches the request and response
// channels, predicts every response and compares it field by field. Depends on ate_pkg, ate_if.
`timescale 1ns / 100ps
module ate_checker import ate_pkg::*; (
  input  logic clk,
  input  logic rst,
  ate_req_if   req,
  ate_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [5:0]  first_idx;
    logic [5:0]  final_idx;
    logic [6:0]  tally;
    logic        last;
  } rsp_item_t;

  rsp_item_t        awaited_q[$];
  logic signed [31:0] table_mem [CAPACITY];
  int               table_len;
  int               mismatches;

  function automatic bit is_prime(logic signed [31:0] v);
    longint d;
    if (v < 2) return 0;
    for (d = 2; d * d <= longint'(v); d++)
      if (longint'(v) % d == 0) return 0;
    return 1;
  endfunction

  function automatic void push_rsp(logic [2:0] st, logic [31:0] val, int fi, int li, int ta,
                                   bit lst);
    rsp_item_t r;
    r.status = st; r.value = val; r.first_idx = fi[5:0]; r.final_idx = li[5:0];
    r.tally = ta[6:0]; r.last = lst;
    awaited_q.push_back(r);
  endfunction

  function automatic void sort_table(bit up);
    int i, j;
    logic signed [31:0] key;
    for (i = 1; i < table_len; i++) begin
      key = table_mem[i];
      j = i;
      while (j > 0 && (up ? key < table_mem[j-1] : table_mem[j-1] < key)) begin
        table_mem[j] = table_mem[j-1];
        j--;
      end
      table_mem[j] = key;
    end
  endfunction

  function automatic void predict_cmd(logic [3:0] cmd, logic signed [31:0] val, int pos);
    int i, cnt, lo, hi, mid, fin;
    logic signed [31:0] t;
    case (cmd)
      CMD_CLEAR: begin
        table_len = 0;
        push_rsp(ST_OK, 0, 0, 0, 0, 1);
      end
      CMD_APPEND: begin
        if (table_len >= CAPACITY) push_rsp(ST_FULL, 0, 0, 0, table_len, 1);
        else begin
          table_mem[table_len] = val;
          table_len++;
          push_rsp(ST_OK, 0, 0, 0, table_len, 1);
        end
      end
      CMD_DUMP: begin
        if (table_len == 0) push_rsp(ST_TOO_FEW, 0, 0, 0, 0, 1);
        for (i = 0; i < table_len; i++)
          push_rsp(ST_OK, table_mem[i], i, 0, table_len, i + 1 == table_len);
      end
      CMD_PRIMES: begin
        cnt = 0;
        for (i = 0; i < table_len; i++) if (is_prime(table_mem[i])) cnt++;
        push_rsp(ST_OK, 0, 0, 0, cnt, 1);
      end
      CMD_SECMIN: begin
        if (table_len < 2) push_rsp(ST_TOO_FEW, 0, 0, 0, table_len, 1);
        else begin
          sort_table(1);
          for (i = 1; i < table_len && table_mem[i] == table_mem[0]; i++) ;
          if (i < table_len) push_rsp(ST_OK, table_mem[i], 0, 0, table_len, 1);
          else push_rsp(ST_NOTFOUND, 0, 0, 0, table_len, 1);
        end
      end
      CMD_INSERT: begin
        if (table_len >= CAPACITY) push_rsp(ST_FULL, 0, 0, 0, table_len, 1);
        else if (pos > table_len) push_rsp(ST_BAD_IDX, 0, 0, 0, table_len, 1);
        else begin
          for (i = table_len; i > pos; i--) table_mem[i] = table_mem[i-1];
          table_mem[pos] = val;
          table_len++;
          push_rsp(ST_OK, 0, 0, 0, table_len, 1);
        end
      end
      CMD_DELETE: begin
        if (pos >= table_len) push_rsp(ST_BAD_IDX, 0, 0, 0, table_len, 1);
        else begin
          for (i = pos; i + 1 < table_len; i++) table_mem[i] = table_mem[i+1];
          table_len--;
          push_rsp(ST_OK, 0, 0, 0, table_len, 1);
        end
      end
      CMD_SORTD: begin
        sort_table(0);
        push_rsp(ST_OK, 0, 0, 0, table_len, 1);
      end
      CMD_SEARCH: begin
        sort_table(1);
        lo = 0; hi = table_len;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (table_mem[mid] < val) lo = mid + 1; else hi = mid;
        end
        if (lo >= table_len || table_mem[lo] != val)
          push_rsp(ST_NOTFOUND, 0, 0, 0, table_len, 1);
        else begin
          fin = lo;
          while (fin + 1 < table_len && table_mem[fin+1] == val) fin++;
          push_rsp(ST_OK, 0, lo, fin, table_len, 1);
        end
      end
      CMD_REVERSE: begin
        lo = 0; hi = table_len;
        while (lo + 1 < hi) begin
          t = table_mem[lo]; table_mem[lo] = table_mem[hi-1]; table_mem[hi-1] = t;
          lo++; hi--;
        end
        push_rsp(ST_OK, 0, 0, 0, table_len, 1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    rsp_item_t e;
    if (rst) begin
      table_len = 0;
      awaited_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected response status=%0d value=%h", $realtime,
                     rsp.status, rsp.result_value);
        end else begin
          e = awaited_q.pop_front();
          if (rsp.status !== e.status || rsp.result_value !== e.value ||
              rsp.first_index !== e.first_idx || rsp.final_index !== e.final_idx ||
              rsp.tally !== e.tally || rsp.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch exp st=%0d val=%h fi=%0d li=%0d ta=%0d last=%0d",
                       $realtime, e.status, e.value, e.first_idx, e.final_idx, e.tally,
                       e.last, "  got st=%0d val=%h fi=%0d li=%0d ta=%0d last=%0d",
                       rsp.status, rsp.result_value, rsp.first_index, rsp.final_index,
                       rsp.tally, rsp.last);
          end
        end
      end
      if (req.valid && req.ready)
        predict_cmd(req.command, req.operand_value, int'(req.position));
    end
    fail_count <= mismatches;
    pending <= awaited_q.size();
  end
endmodule

FILE: verif/array_table_engine_top_tb.sv
// Testbench top for the array table engine: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on ate_pkg, ate_if, ate_checker and the RTL.
`timescale 1ns / 100ps
module array_table_engine_top_tb;
  import ate_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_ITEMS = 110;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   sent;
  bit   calm;   // when set, both sides run without idle gaps

  ate_req_if req_ch (.clk(clk));
  ate_rsp_if rsp_ch (.clk(clk));

  array_table_engine_top dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  ate_checker scoreboard (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung engine or lost response ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response side: stall a random number of cycles before taking each response.
  initial begin
    int stall;
    rsp_ch.ready = 0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1;
      do @(posedge clk); while (!rsp_ch.valid);
    end
  end

  // Issue one request: idle for a random gap, then hold it until accepted.
  // Valid stays high across back-to-back requests.
  task automatic send_req(logic [3:0] cmd, logic [31:0] val, logic [6:0] pos);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1;
    req_ch.command       <= cmd;
    req_ch.operand_value <= val;
    req_ch.position      <= pos;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  // Mostly small values so that matches and duplicates are common; large
  // positive values are kept even so the prime test never runs a long trial.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) begin
      v = $urandom;
      if (!v[31]) v[0] = 1'b0;
    end else begin
      v = $urandom_range(0, 60) - 20;
    end
    return v;
  endfunction

  function automatic logic [6:0] pick_pos();
    return ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 8)) : 7'($urandom_range(0, 64));
  endfunction

  initial begin
    int r, n;
    rst = 1;
    sent = 0;
    calm = 0;
    req_ch.valid = 0;
    req_ch.command = CMD_CLEAR;
    req_ch.operand_value = 0;
    req_ch.position = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty-array corner cases first.
    send_req(CMD_CLEAR, 0, 0);
    send_req(CMD_DUMP, 0, 0);          // empty dump: too few, last set
    send_req(CMD_PRIMES, 0, 0);
    send_req(CMD_SECMIN, 0, 0);        // fewer than two elements
    send_req(CMD_SEARCH, 5, 0);        // search in empty array
    send_req(CMD_DELETE, 0, 0);        // delete on empty array
    send_req(CMD_INSERT, 9, 1);        // insert beyond length
    send_req(CMD_INSERT, 7, 0);
    send_req(CMD_APPEND, 32'h7fff_ffff, 0);
    send_req(CMD_APPEND, 32'h8000_0000, 0);
    send_req(CMD_APPEND, 7, 0);
    send_req(CMD_DUMP, 0, 0);
    send_req(CMD_SECMIN, 0, 0);        // sorts ascending, duplicates of second value
    send_req(CMD_SEARCH, 7, 0);        // two matches
    send_req(CMD_SEARCH, 5, 0);        // no match
    send_req(CMD_SORTD, 0, 0);
    send_req(CMD_REVERSE, 0, 0);
    send_req(CMD_DELETE, 0, 4);        // position equal to length
    send_req(CMD_DELETE, 0, 0);
    send_req(CMD_INSERT, -1, 3);       // insert at the end
    send_req(4'd12, 0, 0);             // unused command: no response
    send_req(CMD_DUMP, 0, 0);
    send_req(CMD_CLEAR, 0, 0);         // drop the large prime before any prime count
    send_req(CMD_APPEND, 3, 0);
    send_req(CMD_APPEND, 3, 0);
    send_req(CMD_SECMIN, 0, 0);        // all equal: not found
    send_req(CMD_APPEND, -7, 0);
    send_req(CMD_PRIMES, 0, 0);        // negative values are not prime

    // Random: weighted toward appends so the array grows, with one fill to capacity.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 20) begin
        send_req(CMD_CLEAR, 0, 0);
        repeat (CAPACITY) send_req(CMD_APPEND, pick_value(), 0);
        send_req(CMD_APPEND, 1, 0);    // full
        send_req(CMD_INSERT, 1, 64);   // full wins over the index check
        send_req(CMD_DELETE, 0, 64);   // out of range
        send_req(CMD_DELETE, 0, 63);
        send_req(CMD_INSERT, pick_value(), 63);
        n += 70;
      end
      if (n == 90) begin
        // Hold off until the engine has answered everything.
        req_ch.valid <= 0;
        do @(posedge clk); while (pending != 0);
      end
      r = $urandom_range(0, 99);
      if      (r < 30) send_req(CMD_APPEND, pick_value(), 0);
      else if (r < 38) send_req(CMD_INSERT, pick_value(), pick_pos());
      else if (r < 50) send_req(CMD_DELETE, 0, pick_pos());
      else if (r < 55) send_req(CMD_DUMP, $urandom, pick_pos());
      else if (r < 60) send_req(CMD_PRIMES, $urandom, pick_pos());
      else if (r < 66) send_req(CMD_SECMIN, 0, 0);
      else if (r < 72) send_req(CMD_SORTD, 0, 0);
      else if (r < 84) send_req(CMD_SEARCH, pick_value(), 0);
      else if (r < 90) send_req(CMD_REVERSE, 0, 0);
      else if (r < 93) send_req(CMD_CLEAR, $urandom, pick_pos());
      else begin
        send_req(4'($urandom_range(10, 15)), $urandom, pick_pos());
        n--;                           // ignored commands do not count
      end
      n++;
    end
    req_ch.valid <= 0;

    // Drain, then allow the engine to settle before the verdict.
    do @(posedge clk); while (pending != 0);
    calm = 1;
    repeat (500) @(posedge clk);

    $display("Ran %0d requests: every command, empty and full array, bad indices,", sent);
    $display("ignored commands and random stalls on both channels, %0d cycles.", cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d responses missing", fail_count, pending);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
